// ----- hdl/mrf_pkg.sv -----
// ----------------------------------------------------------------------------
// mrf_pkg
// shared types, sizes and helpers of the message ring fifo
// ----------------------------------------------------------------------------
package mrf_pkg;

  localparam int SLOTS       = 16;
  localparam int MSG_BYTES   = 64;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int OFS_W       = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int LEN_W       = 7;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int MEM_DEPTH   = SLOTS * MSG_BYTES;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_PUT  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_SKIP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

  // one classified operation handed from front to back
  typedef struct packed {
    logic              wr_en;       // store data at wr_slot/wr_pos
    logic [SLOT_W-1:0] wr_slot;
    logic [OFS_W-1:0]  wr_pos;
    logic [7:0]        data;
    logic              has_status;  // one status-only result
    status_t           status;
    logic              stream;      // stream rd_slot, len bytes
    logic [SLOT_W-1:0] rd_slot;
    logic [LEN_W-1:0]  len;
  } queue_entry_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] i);
    return (i == SLOT_W'(SLOTS - 1)) ? '0 : i + SLOT_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_W-1:0] slot,
                                                 input logic [OFS_W-1:0] ofs);
    return ADDR_W'(slot) * ADDR_W'(MSG_BYTES) + ADDR_W'(ofs);
  endfunction

endpackage

// ----- hdl/mrf_front.sv -----
// ----------------------------------------------------------------------------
// mrf_front
// accepts input transactions, tracks slot bookkeeping, emits queue entries
// ----------------------------------------------------------------------------
module mrf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [1:0]           in_cmd,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  output mrf_pkg::queue_entry_t entry
);
  import mrf_pkg::*;

  logic [SLOT_W-1:0] widx_r, widx_nxt;
  logic [SLOT_W-1:0] ridx_r, ridx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic              ov_r, ov_nxt;
  logic              blk_r, blk_nxt;

  logic [LEN_W-1:0]  slot_len [SLOTS];
  logic              len_we;
  logic [LEN_W-1:0]  fill_inc;
  logic              full, fits, ov_now, blk_now;
  cmd_t              cmd;

  assign cmd      = cmd_t'(in_cmd);
  assign full     = (cnt_r == CNT_W'(SLOTS));
  assign fits     = (fill_r < LEN_W'(MSG_BYTES));
  assign ov_now   = ov_r | ~fits;
  assign blk_now  = blk_r | full;
  assign fill_inc = fits ? fill_r + LEN_W'(1) : fill_r;

  always_comb begin
    entry            = '0;
    entry.wr_slot    = widx_r;
    entry.wr_pos     = OFS_W'(fill_r);
    entry.data       = in_data_byte;
    entry.status     = ST_OK;
    entry.rd_slot    = ridx_r;
    entry.len        = slot_len[ridx_r];
    widx_nxt         = widx_r;
    ridx_nxt         = ridx_r;
    cnt_nxt          = cnt_r;
    fill_nxt         = fill_r;
    ov_nxt           = ov_r;
    blk_nxt          = blk_r;
    len_we           = 1'b0;
    unique case (cmd)
      CMD_PUT: begin
        entry.wr_en = fits & ~full;
        fill_nxt    = fill_inc;
        ov_nxt      = ov_now;
        blk_nxt     = blk_now;
        if (in_last_byte) begin
          entry.has_status = 1'b1;
          fill_nxt         = '0;
          ov_nxt           = 1'b0;
          blk_nxt          = 1'b0;
          priority if (ov_now) begin
            entry.status = ST_LONG;
          end else if (blk_now) begin
            entry.status = ST_FULL;
          end else begin
            entry.status = ST_OK;
            len_we       = 1'b1;
            widx_nxt     = next_slot(widx_r);
            cnt_nxt      = cnt_r + CNT_W'(1);
          end
        end
      end
      CMD_GET, CMD_PEEK, CMD_SKIP: begin
        if (cnt_r == '0) begin
          entry.has_status = 1'b1;
          entry.status     = ST_EMPTY;
        end else begin
          if (cmd == CMD_SKIP) begin
            entry.has_status = 1'b1;
          end else begin
            entry.stream = 1'b1;
          end
          if (cmd != CMD_PEEK) begin
            ridx_nxt = next_slot(ridx_r);
            cnt_nxt  = cnt_r - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0;
      ridx_r <= '0;
      cnt_r  <= '0;
      fill_r <= '0;
      ov_r   <= 1'b0;
      blk_r  <= 1'b0;
    end else if (push) begin
      widx_r <= widx_nxt;
      ridx_r <= ridx_nxt;
      cnt_r  <= cnt_nxt;
      fill_r <= fill_nxt;
      ov_r   <= ov_nxt;
      blk_r  <= blk_nxt;
    end
  end

  // committed lengths, written only on commit
  always_ff @(posedge clk) begin
    if (push && len_we) begin
      slot_len[widx_r] <= fill_inc;
    end
  end

endmodule

// ----- hdl/mrf_queue.sv -----
// ----------------------------------------------------------------------------
// mrf_queue
// short fifo of classified operations between front and back
// ----------------------------------------------------------------------------
module mrf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mrf_pkg::queue_entry_t push_entry,
  input  logic                 pop,
  output logic                 full,
  output logic                 head_valid,
  output mrf_pkg::queue_entry_t head
);
  import mrf_pkg::*;

  queue_entry_t      entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = entries[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr_r] <= push_entry;
    end
  end

endmodule

// ----- hdl/mrf_back.sv -----
// ----------------------------------------------------------------------------
// mrf_back
// byte store, message streaming and the result output register
// ----------------------------------------------------------------------------
module mrf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  mrf_pkg::queue_entry_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [7:0]           out_byte,
  output logic [6:0]           out_msg_length,
  output logic                 out_last_out
);
  import mrf_pkg::*;

  logic [7:0]        byte_mem [MEM_DEPTH];
  logic [7:0]        rd_data_r;

  // streaming sequencer
  logic              streaming_r;
  logic [SLOT_W-1:0] slot_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  pos_r;
  logic              st_issue, st_last;

  // read stage
  logic              s1_valid_r;
  logic              s1_is_byte_r;
  status_t           s1_status_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic              s1_last_r;
  logic              s1_adv, s1_free, s1_load;

  // output register
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [7:0]        out_byte_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_last_r;
  logic              out_load;

  logic              head_result, wr_conflict, mem_we;

  assign out_load    = !out_valid_r || !out_stall;
  assign s1_adv      = s1_valid_r && out_load;
  assign s1_free     = !s1_valid_r || s1_adv;
  assign st_issue    = streaming_r && s1_free;
  assign st_last     = (pos_r == len_r - LEN_W'(1));

  // a write may pass a running stream unless it hits the slot being streamed
  assign head_result = head.stream || head.has_status;
  assign wr_conflict = streaming_r && head.wr_en && (head.wr_slot == slot_r);
  assign pop = head_valid && (head_result ? (!streaming_r && s1_free) : !wr_conflict);
  assign mem_we  = pop && head.wr_en;
  assign s1_load = st_issue || (pop && head.has_status);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_mem[mem_addr(head.wr_slot, head.wr_pos)] <= head.data;
    end
    if (st_issue) begin
      rd_data_r <= byte_mem[mem_addr(slot_r, OFS_W'(pos_r))];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      streaming_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && head.stream) begin
        streaming_r <= 1'b1;
      end else if (st_issue && st_last) begin
        streaming_r <= 1'b0;
      end
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.stream) begin
      slot_r <= head.rd_slot;
      len_r  <= head.len;
      pos_r  <= '0;
    end else if (st_issue) begin
      pos_r <= pos_r + LEN_W'(1);
    end
    if (s1_load) begin
      s1_is_byte_r <= st_issue;
      s1_status_r  <= st_issue ? ST_OK : head.status;
      s1_len_r     <= st_issue ? len_r : '0;
      s1_last_r    <= st_issue ? st_last : 1'b1;
    end
    if (s1_adv) begin
      out_status_r <= s1_status_r;
      out_byte_r   <= s1_is_byte_r ? rd_data_r : 8'd0;
      out_len_r    <= s1_len_r;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_byte       = out_byte_r;
  assign out_msg_length = out_len_r;
  assign out_last_out   = out_last_r;

endmodule

// ----- hdl/message_ring_fifo.sv -----
// ----------------------------------------------------------------------------
// message_ring_fifo
// ring fifo of whole messages in fixed slots, put byte by byte, read by
// get, peek or skip
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_stall): one transaction per command; a put
//   sends one byte per transaction with in_last_byte on the final byte
//   output channel (out_valid/out_stall): a put's last byte and every skip
//   or empty command give one status transaction; get and peek give one
//   transaction per message byte, with out_last_out on the final one
//   front: accepts a transaction per cycle while in_stall is low and settles
//   slot bookkeeping at once
//   queue: four classified operations, so the front keeps taking puts while
//   the back streams a message
//   back: one byte store with one write and one registered read port
//   path: a status result passes the queue, read stage and output register;
//   a streamed byte also passes the streaming sequencer before the read stage
//   throughput: puts go in at one byte per cycle while in_stall is low; a
//   stalled output fills the read stage and the queue, then in_stall rises
//   reset: all slots empty, no put in progress; stored bytes are not cleared
// ----------------------------------------------------------------------------
module message_ring_fifo (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_byte,
  output logic [6:0] out_msg_length,
  output logic       out_last_out
);
  import mrf_pkg::*;

  queue_entry_t entry;
  queue_entry_t head;
  logic         q_full;
  logic         head_valid;
  logic         push;
  logic         pop;

  // stall only when the queue cannot take another operation
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  mrf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .entry        (entry)
  );

  mrf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  mrf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_byte       (out_byte),
    .out_msg_length (out_msg_length),
    .out_last_out   (out_last_out)
  );

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives put, get, peek and skip commands into message_ring_fifo, follows
// every accepted command with a shadow copy of the slot ring, and checks each
// output transaction field by field against the oldest predicted response
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mrf_pkg::*;

  // one predicted output transaction
  typedef struct {
    status_t    status;
    logic [7:0] data;
    logic [6:0] len;
    logic       is_last;
  } response_t;

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [1:0] in_cmd       = CMD_PUT;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_byte;
  logic [6:0] out_msg_length;
  logic       out_last_out;

  // shadow copy of the ring and of the put in progress
  logic [7:0] shadow_bytes [SLOTS][MSG_BYTES];
  logic [6:0] shadow_len [SLOTS];
  int         head_slot     = 0;
  int         tail_slot     = 0;
  int         held_msgs     = 0;
  int         put_fill      = 0;
  bit         put_overflow  = 1'b0;
  bit         put_blocked   = 1'b0;

  // responses still owed by the fifo, oldest first
  response_t  expected_responses[$];

  // idle and stall odds in percent, changed between test phases
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // run statistics
  int mismatch_count = 0;
  int items_sent     = 0;
  int outputs_seen   = 0;
  int cmd_count [4];
  int status_count [4];

  message_ring_fifo dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_byte       (out_byte),
    .out_msg_length (out_msg_length),
    .out_last_out   (out_last_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the fifo hangs or loses a response
  initial begin
    #50_000_000;
    $display("[message_ring_fifo] ERROR");
    $finish;
  end

  // receiver back-pressure, random per cycle at the current odds
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // queue one status-only response
  function automatic void owe_status(input status_t st);
    expected_responses.push_back('{st, 8'h00, 7'd0, 1'b1});
    status_count[st]++;
  endfunction

  // apply one accepted command to the shadow ring and queue its responses
  function automatic void shadow_step(input cmd_t cmd, input logic [7:0] data,
                                      input logic is_last);
    bit full;
    int n;
    if (cmd == CMD_PUT) begin
      full = (held_msgs >= SLOTS);
      // a byte that meets a full ring poisons the whole message
      if (full) put_blocked = 1'b1;
      if (put_fill < MSG_BYTES) begin
        // when full the write slot is the head slot, so nothing is stored
        if (!full) shadow_bytes[tail_slot][put_fill] = data;
        put_fill++;
      end else begin
        put_overflow = 1'b1;
      end
      if (is_last) begin
        // too long takes priority over full
        if (put_overflow) begin
          owe_status(ST_LONG);
        end else if (put_blocked) begin
          owe_status(ST_FULL);
        end else begin
          shadow_len[tail_slot] = 7'(put_fill);
          tail_slot = (tail_slot + 1) % SLOTS;
          held_msgs++;
          owe_status(ST_OK);
        end
        put_fill     = 0;
        put_overflow = 1'b0;
        put_blocked  = 1'b0;
      end
    end else if (held_msgs == 0) begin
      owe_status(ST_EMPTY);
    end else if (cmd == CMD_SKIP) begin
      head_slot = (head_slot + 1) % SLOTS;
      held_msgs--;
      owe_status(ST_OK);
    end else begin
      // get and peek stream the head message, one transaction per byte
      n = int'(shadow_len[head_slot]);
      for (int i = 0; i < n; i++)
        expected_responses.push_back('{ST_OK, shadow_bytes[head_slot][i],
                                       7'(n), (i == n - 1)});
      if (cmd == CMD_GET) begin
        head_slot = (head_slot + 1) % SLOTS;
        held_msgs--;
      end
    end
  endfunction

  // present one command, hold it until accepted, then predict its responses;
  // valid stays high into the next command unless the sender decides to idle
  task automatic send_item(input cmd_t cmd, input logic [7:0] data,
                           input logic is_last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_data_byte <= data;
    in_last_byte <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow_step(cmd, data, is_last);
    cmd_count[cmd]++;
    items_sent++;
  endtask

  // put a message of random bytes; with interleave set, reads may land
  // between its bytes
  task automatic send_message(input int n_bytes, input bit interleave);
    for (int i = 0; i < n_bytes; i++) begin
      if (interleave && $urandom_range(99) < 6)
        send_item(cmd_t'($urandom_range(3, 1)), 8'($urandom_range(255)),
                  1'($urandom_range(1)));
      send_item(CMD_PUT, 8'($urandom_range(255)), (i == n_bytes - 1));
    end
  endtask

  // get, peek and skip with nothing stored
  task automatic test_empty_fifo();
    send_item(CMD_GET,  8'($urandom_range(255)), 1'b0);
    send_item(CMD_PEEK, 8'($urandom_range(255)), 1'b1);
    send_item(CMD_SKIP, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // short messages, byte extremes, every read command, reads inside a put
  task automatic test_put_and_read();
    send_item(CMD_PUT,  8'h00, 1'b1);
    send_item(CMD_PUT,  8'hff, 1'b0);
    send_item(CMD_PUT,  8'h5a, 1'b0);
    send_item(CMD_PUT,  8'hc3, 1'b1);
    send_item(CMD_PEEK, 8'hff, 1'b1);
    send_item(CMD_GET,  8'h00, 1'b0);
    // a put left open while the reads are served
    send_item(CMD_PUT,  8'h7e, 1'b0);
    send_item(CMD_PEEK, 8'h00, 1'b0);
    send_item(CMD_SKIP, 8'hff, 1'b1);
    send_item(CMD_GET,  8'h12, 1'b1);
    send_item(CMD_PUT,  8'h81, 1'b1);
    send_item(CMD_GET,  8'h34, 1'b0);
  endtask

  // fill every slot, then reject for full and for length, then the largest
  // message that fits, and drain
  task automatic test_full_and_overlong();
    repeat (SLOTS) send_message(1, 1'b0);
    send_message(MSG_BYTES + 1, 1'b0);
    send_message(2, 1'b0);
    // a slot frees up mid-put, but the message was already refused
    send_item(CMD_PUT, 8'($urandom_range(255)), 1'b0);
    send_item(CMD_GET, 8'($urandom_range(255)), 1'($urandom_range(1)));
    send_item(CMD_PUT, 8'($urandom_range(255)), 1'b1);
    send_message(MSG_BYTES, 1'b0);
    send_item(CMD_PEEK, 8'($urandom_range(255)), 1'($urandom_range(1)));
    repeat (SLOTS)
      send_item(CMD_GET, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // mostly whole messages of random content, mixed with reads and stray bytes
  task automatic test_random_traffic(input int budget);
    int stop_at;
    int pick;
    int n;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // mostly short messages, a few at or past the slot size
        n = $urandom_range(99);
        if (n < 70)      n = $urandom_range(4, 1);
        else if (n < 90) n = $urandom_range(16, 5);
        else if (n < 96) n = $urandom_range(MSG_BYTES - 1, 17);
        else if (n < 98) n = MSG_BYTES;
        else             n = $urandom_range(MSG_BYTES + 3, MSG_BYTES + 1);
        send_message(n, 1'b1);
      end else if (pick < 68) begin
        send_item(CMD_GET, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (pick < 80) begin
        send_item(CMD_PEEK, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (pick < 92) begin
        send_item(CMD_SKIP, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        // fully random command, may leave a put half done
        send_item(cmd_t'($urandom_range(3)), 8'($urandom_range(255)),
                  1'($urandom_range(1)));
      end
    end
  endtask

  // compare each accepted output transaction with the oldest prediction
  always @(posedge clk) begin : check_output
    response_t want;
    if (rst_n && out_valid && !out_stall) begin
      outputs_seen++;
      if (expected_responses.size() == 0) begin
        $error("unexpected transaction: status %0d byte %0h length %0d last %0b",
               out_status, out_byte, out_msg_length, out_last_out);
        mismatch_count++;
      end else begin
        want = expected_responses.pop_front();
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_byte);
          mismatch_count++;
        end
        if (out_msg_length !== want.len) begin
          $error("out_msg_length: expected %0d, got %0d", want.len, out_msg_length);
          mismatch_count++;
        end
        if (out_last_out !== want.is_last) begin
          $error("out_last_out: expected %0b, got %0b", want.is_last, out_last_out);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    // synchronous reset, then release
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // slow receiver: output stalls pile up, in_stall gets exercised
    send_idle_pct  = 11;
    recv_stall_pct = 82;
    test_empty_fifo();
    test_put_and_read();
    test_full_and_overlong();

    // slow sender: the fifo runs mostly drained
    send_idle_pct  = 82;
    recv_stall_pct = 11;
    test_random_traffic(125);

    // back to back on both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(125);
    in_valid <= 1'b0;

    // drain outstanding responses, then watch for stray transactions
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d commands: %0d put bytes, %0d get, %0d peek, %0d skip; %0d outputs",
             items_sent, cmd_count[CMD_PUT], cmd_count[CMD_GET],
             cmd_count[CMD_PEEK], cmd_count[CMD_SKIP], outputs_seen);
    $display("status results: ok %0d, full %0d, empty %0d, too long %0d",
             status_count[ST_OK], status_count[ST_FULL],
             status_count[ST_EMPTY], status_count[ST_LONG]);
    if (mismatch_count == 0) begin
      $display("[message_ring_fifo] OK");
    end else begin
      $display("[message_ring_fifo] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/mrf_pkg.sv
hdl/mrf_front.sv
hdl/mrf_queue.sv
hdl/mrf_back.sv
hdl/message_ring_fifo.sv
sim/testbench.sv
